>>> design/vvau_pkg.sv
`timescale 1ns / 1ps

package vvau_pkg;

  localparam int WORD_W     = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_W     = 2 * WORD_W + 1;
  localparam int SQ_W       = 2 * WORD_W;
  localparam int SUM_W      = 48;
  localparam int BOX_W      = 31;
  localparam int LANES      = 3;
  localparam int PIPE_DEPTH = 7;
  localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);
  localparam int IDX_W      = 3;

  localparam logic signed [PROD_W-1:0] WIDE_MAX = PROD_W'(2147483647);
  localparam logic signed [PROD_W-1:0] WIDE_MIN = -PROD_W'(64'sd2147483648);
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic [SUM_W-1:0]         SUM_MAX  = {SUM_W{1'b1}};

  localparam logic [WORD_W-1:0] TIME_STEP_RST    = 32'd1311;
  localparam logic [WORD_W-1:0] INVERSE_MASS_RST = 32'd65536;
  localparam logic [WORD_W-1:0] HALF_MASS_RST    = 32'd32768;
  localparam logic [BOX_W-1:0]  BOX_SIZE_RST     = 31'd655360;

  typedef enum logic [IDX_W-1:0] {
    REG_TIME_STEP    = 3'd0,
    REG_INVERSE_MASS = 3'd1,
    REG_HALF_MASS    = 3'd2,
    REG_BOX_SIZE     = 3'd3,
    REG_WRAP_ENABLE  = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } state_t;

  typedef struct packed {
    logic [WORD_W-1:0] time_step;
    logic [WORD_W-1:0] inverse_mass;
    logic [WORD_W-1:0] half_mass;
    logic [BOX_W-1:0]  box_size;
    logic              wrap_enable;
  } cfg_t;

  typedef struct packed {
    logic commit;
    logic energy_mode;
    logic last;
  } merge_ctl_t;

  function automatic logic signed [WORD_W-1:0] clamp_word(input logic signed [PROD_W-1:0] v);
    if (v > WIDE_MAX) begin
      return WORD_MAX;
    end else if (v < WIDE_MIN) begin
      return WORD_MIN;
    end
    return $signed(v[WORD_W-1:0]);
  endfunction

endpackage

>>> design/velocity_verlet_atom_update_core.sv
`timescale 1ns / 1ps
// An input transaction reaches out_valid through the sequencer and one output register.
// One atom is in flight at a time while it passes through the seven-stage
// multiply pipeline of the three axis lanes and the energy merge.
// A finished result waits in the output register while the next atom is accepted.
// Reset (rst, synchronous, active high): clears control and the kinetic energy sum,
// returns all configuration registers to their default values.

module velocity_verlet_atom_update_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [vvau_pkg::IDX_W-1:0]            cfg_index,
  input  logic [vvau_pkg::WORD_W-1:0]           cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  req_type,
  input  logic signed [vvau_pkg::WORD_W-1:0]    force_x,
  input  logic signed [vvau_pkg::WORD_W-1:0]    force_y,
  input  logic signed [vvau_pkg::WORD_W-1:0]    force_z,
  input  logic signed [vvau_pkg::WORD_W-1:0]    vel_x_in,
  input  logic signed [vvau_pkg::WORD_W-1:0]    vel_y_in,
  input  logic signed [vvau_pkg::WORD_W-1:0]    vel_z_in,
  input  logic signed [vvau_pkg::WORD_W-1:0]    pos_x_in,
  input  logic signed [vvau_pkg::WORD_W-1:0]    pos_y_in,
  input  logic signed [vvau_pkg::WORD_W-1:0]    pos_z_in,
  input  logic                                  last_atom,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [vvau_pkg::WORD_W-1:0]    vel_x_out,
  output logic signed [vvau_pkg::WORD_W-1:0]    vel_y_out,
  output logic signed [vvau_pkg::WORD_W-1:0]    vel_z_out,
  output logic signed [vvau_pkg::WORD_W-1:0]    pos_x_out,
  output logic signed [vvau_pkg::WORD_W-1:0]    pos_y_out,
  output logic signed [vvau_pkg::WORD_W-1:0]    pos_z_out,
  output logic [vvau_pkg::SUM_W-1:0]            kinetic_total,
  output logic                                  total_valid
);

  vvau_pkg::cfg_t                        cfg;
  vvau_pkg::state_t                      state;
  vvau_pkg::state_t                      state_next;
  vvau_pkg::merge_ctl_t                  merge_ctl;
  logic [vvau_pkg::CNT_W-1:0]            cnt;
  logic                                  in_take;
  logic                                  commit;
  logic                                  energy_mode;
  logic                                  last_q;
  logic signed [vvau_pkg::WORD_W-1:0]    force_q [vvau_pkg::LANES];
  logic signed [vvau_pkg::WORD_W-1:0]    vel_q   [vvau_pkg::LANES];
  logic signed [vvau_pkg::WORD_W-1:0]    pos_q   [vvau_pkg::LANES];
  logic signed [vvau_pkg::WORD_W-1:0]    vel_new [vvau_pkg::LANES];
  logic signed [vvau_pkg::WORD_W-1:0]    pos_new [vvau_pkg::LANES];
  logic signed [vvau_pkg::WORD_W-1:0]    pos_sel [vvau_pkg::LANES];
  logic [vvau_pkg::SQ_W-1:0]             vel_sq  [vvau_pkg::LANES];
  logic [vvau_pkg::SUM_W-1:0]            total;
  logic                                  total_flag;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.time_step    <= vvau_pkg::TIME_STEP_RST;
      cfg.inverse_mass <= vvau_pkg::INVERSE_MASS_RST;
      cfg.half_mass    <= vvau_pkg::HALF_MASS_RST;
      cfg.box_size     <= vvau_pkg::BOX_SIZE_RST;
      cfg.wrap_enable  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vvau_pkg::REG_TIME_STEP:    cfg.time_step    <= cfg_data;
        vvau_pkg::REG_INVERSE_MASS: cfg.inverse_mass <= cfg_data;
        vvau_pkg::REG_HALF_MASS:    cfg.half_mass    <= cfg_data;
        vvau_pkg::REG_BOX_SIZE:     cfg.box_size     <= cfg_data[vvau_pkg::BOX_W-1:0];
        vvau_pkg::REG_WRAP_ENABLE:  cfg.wrap_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_stall = (state != vvau_pkg::ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign commit   = (state == vvau_pkg::ST_BUSY) && (cnt == vvau_pkg::CNT_W'(vvau_pkg::PIPE_DEPTH))
                    && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    case (state)
      vvau_pkg::ST_IDLE: if (in_take) state_next = vvau_pkg::ST_BUSY;
      vvau_pkg::ST_BUSY: if (commit) state_next = vvau_pkg::ST_IDLE;
      default: state_next = vvau_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vvau_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (in_take) begin
        cnt <= '0;
      end else if (state == vvau_pkg::ST_BUSY && cnt != vvau_pkg::CNT_W'(vvau_pkg::PIPE_DEPTH)) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      energy_mode <= req_type;
      last_q      <= last_atom;
      force_q[0]  <= force_x;
      force_q[1]  <= force_y;
      force_q[2]  <= force_z;
      vel_q[0]    <= vel_x_in;
      vel_q[1]    <= vel_y_in;
      vel_q[2]    <= vel_z_in;
      pos_q[0]    <= pos_x_in;
      pos_q[1]    <= pos_y_in;
      pos_q[2]    <= pos_z_in;
    end
  end

  for (genvar g = 0; g < vvau_pkg::LANES; g++) begin : g_lane
    vvau_lane u_lane (
      .clk      (clk),
      .cfg      (cfg),
      .force_in (force_q[g]),
      .vel_in   (vel_q[g]),
      .pos_in   (pos_q[g]),
      .vel_new  (vel_new[g]),
      .pos_new  (pos_new[g]),
      .vel_sq   (vel_sq[g])
    );
    assign pos_sel[g] = energy_mode ? pos_q[g] : pos_new[g];
  end

  assign merge_ctl.commit      = commit;
  assign merge_ctl.energy_mode = energy_mode;
  assign merge_ctl.last        = last_q;

  vvau_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .half_mass  (cfg.half_mass),
    .vel_sq     (vel_sq),
    .ctl        (merge_ctl),
    .total      (total),
    .total_flag (total_flag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      vel_x_out     <= vel_new[0];
      vel_y_out     <= vel_new[1];
      vel_z_out     <= vel_new[2];
      pos_x_out     <= pos_sel[0];
      pos_y_out     <= pos_sel[1];
      pos_z_out     <= pos_sel[2];
      kinetic_total <= total;
      total_valid   <= total_flag;
    end
  end

  a_accept_starts_busy: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == vvau_pkg::ST_BUSY) && (cnt == '0))
    else $error("accepted transaction did not start the sequencer");

  a_commit_loads_output: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid && (state == vvau_pkg::ST_IDLE))
    else $error("commit did not load the output register");

  a_no_commit_early: assert property (@(posedge clk) disable iff (rst)
    commit |-> $past(state) == vvau_pkg::ST_BUSY)
    else $error("commit without a busy sequencer");

  a_total_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !total_valid) |-> (kinetic_total == '0))
    else $error("kinetic total nonzero without total_valid");

endmodule

>>> design/vvau_lane.sv
`timescale 1ns / 1ps

module vvau_lane (
  input  logic                                    clk,
  input  vvau_pkg::cfg_t                          cfg,
  input  logic signed [vvau_pkg::WORD_W-1:0]      force_in,
  input  logic signed [vvau_pkg::WORD_W-1:0]      vel_in,
  input  logic signed [vvau_pkg::WORD_W-1:0]      pos_in,
  output logic signed [vvau_pkg::WORD_W-1:0]      vel_new,
  output logic signed [vvau_pkg::WORD_W-1:0]      pos_new,
  output logic [vvau_pkg::SQ_W-1:0]               vel_sq
);

  logic signed [vvau_pkg::WORD_W:0]        inv_s;
  logic signed [vvau_pkg::WORD_W:0]        ts_s;
  logic signed [vvau_pkg::PROD_W-1:0]      prod_fm;
  logic signed [vvau_pkg::PROD_W-1:0]      prod_at;
  logic signed [vvau_pkg::PROD_W-1:0]      prod_vt;
  logic signed [vvau_pkg::WORD_W-1:0]      accel;
  logic signed [vvau_pkg::WORD_W-1:0]      dv;
  logic signed [vvau_pkg::WORD_W-1:0]      dx;
  logic signed [vvau_pkg::WORD_W-1:0]      pos_sum;
  logic [vvau_pkg::WORD_W-1:0]             vmag;
  logic signed [vvau_pkg::WORD_W:0]        pos_ext;
  logic signed [vvau_pkg::WORD_W:0]        box_ext;
  logic signed [vvau_pkg::WORD_W:0]        wrapped;

  assign inv_s = $signed({1'b0, cfg.inverse_mass});
  assign ts_s  = $signed({1'b0, cfg.time_step});

  always_comb begin
    accel   = vvau_pkg::clamp_word(prod_fm >>> vvau_pkg::FRAC_BITS);
    dv      = vvau_pkg::clamp_word(prod_at >>> (vvau_pkg::FRAC_BITS + 1));
    dx      = vvau_pkg::clamp_word(prod_vt >>> vvau_pkg::FRAC_BITS);
    vmag    = vel_new[vvau_pkg::WORD_W-1] ? vvau_pkg::WORD_W'(-vel_new) : vel_new;
    pos_ext = (vvau_pkg::WORD_W + 1)'(pos_sum);
    box_ext = $signed({2'b00, cfg.box_size});
    wrapped = pos_ext;
    if (cfg.wrap_enable) begin
      if (pos_ext < 0) begin
        wrapped = pos_ext + box_ext;
      end else if (pos_ext >= box_ext) begin
        wrapped = pos_ext - box_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_fm <= force_in * inv_s;
    prod_at <= accel * ts_s;
    vel_new <= vvau_pkg::clamp_word(vvau_pkg::PROD_W'(vel_in) + vvau_pkg::PROD_W'(dv));
    prod_vt <= vel_new * ts_s;
    vel_sq  <= vvau_pkg::SQ_W'(vmag) * vvau_pkg::SQ_W'(vmag);
    pos_sum <= vvau_pkg::clamp_word(vvau_pkg::PROD_W'(pos_in) + vvau_pkg::PROD_W'(dx));
    pos_new <= $signed(wrapped[vvau_pkg::WORD_W-1:0]);
  end

endmodule

>>> design/vvau_merge.sv
`timescale 1ns / 1ps

module vvau_merge (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [vvau_pkg::WORD_W-1:0]   half_mass,
  input  logic [vvau_pkg::SQ_W-1:0]     vel_sq [vvau_pkg::LANES],
  input  vvau_pkg::merge_ctl_t          ctl,
  output logic [vvau_pkg::SUM_W-1:0]    total,
  output logic                          total_flag
);

  logic [vvau_pkg::SQ_W-1:0]    vsq;
  logic [vvau_pkg::SQ_W-1:0]    prod_hi;
  logic [vvau_pkg::SQ_W-1:0]    prod_lo;
  logic [vvau_pkg::SQ_W:0]      energy_wide;
  logic [vvau_pkg::SUM_W-1:0]   energy;
  logic [vvau_pkg::SUM_W-1:0]   kinetic_sum;
  logic [vvau_pkg::SUM_W:0]     sum_wide;
  logic [vvau_pkg::SUM_W-1:0]   sum_sat;

  always_comb begin
    energy_wide = {1'b0, prod_hi}
                + {{(vvau_pkg::WORD_W + 1){1'b0}}, prod_lo[vvau_pkg::SQ_W-1:vvau_pkg::WORD_W]};
    sum_wide    = {1'b0, kinetic_sum} + {1'b0, energy};
    sum_sat     = sum_wide[vvau_pkg::SUM_W] ? vvau_pkg::SUM_MAX : sum_wide[vvau_pkg::SUM_W-1:0];
    total_flag  = ctl.energy_mode && ctl.last;
    total       = total_flag ? sum_sat : '0;
  end

  always_ff @(posedge clk) begin
    vsq     <= vel_sq[0] + vel_sq[1] + vel_sq[2];
    prod_hi <= vvau_pkg::SQ_W'(vsq[vvau_pkg::SQ_W-1:vvau_pkg::WORD_W]) * vvau_pkg::SQ_W'(half_mass);
    prod_lo <= vvau_pkg::SQ_W'(vsq[vvau_pkg::WORD_W-1:0]) * vvau_pkg::SQ_W'(half_mass);
    if (energy_wide > (vvau_pkg::SQ_W + 1)'(vvau_pkg::SUM_MAX)) begin
      energy <= vvau_pkg::SUM_MAX;
    end else begin
      energy <= energy_wide[vvau_pkg::SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kinetic_sum <= '0;
    end else if (ctl.commit && ctl.energy_mode) begin
      kinetic_sum <= ctl.last ? '0 : sum_sat;
    end
  end

endmodule
